/* rtl/heat_diffusion_stencil_2d_assert.svh */
// Assertion shorthands for the stencil modules.
`ifndef HEAT_DIFFUSION_STENCIL_2D_ASSERT_SVH
`define HEAT_DIFFUSION_STENCIL_2D_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define HDS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("stencil assertion failed");

// Next-cycle implication, quiet while reset is held.
`define HDS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("stencil assertion failed");

`endif

/* rtl/hds_pkg.sv */
package hds_pkg;

  localparam int unsigned MaxWidth    = 63;
  localparam int unsigned MaxLength   = 1024;
  localparam int unsigned TempW       = 16;
  localparam int unsigned FactorW     = 16;
  localparam int unsigned GridWidthW  = 6;
  localparam int unsigned GridLengthW = 11;
  localparam int unsigned RowW        = $clog2(MaxLength);
  localparam int unsigned PtrW        = $clog2(2 * MaxWidth + 2);
  localparam int unsigned LineDepth   = 2 ** PtrW;
  localparam int unsigned LapW        = TempW + 4;
  localparam int unsigned ProdW       = LapW + FactorW + 1;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [FactorW-1:0]     FactorReset = FactorW'(13107);
  localparam logic [GridWidthW-1:0]  WidthReset  = GridWidthW'(32);
  localparam logic [GridLengthW-1:0] LengthReset = GridLengthW'(32);

  typedef enum logic [CfgIdxW-1:0] {
    CfgFactor = 2'd0,
    CfgWidth  = 2'd1,
    CfgLength = 2'd2
  } cfg_idx_e;

  typedef logic signed [TempW-1:0] temp_t;

  // Per-cell control that travels with the cell down the pipeline.
  typedef struct packed {
    logic                  emit;
    logic                  interior;
    logic                  flush;
    logic [GridWidthW-1:0] width;
  } cell_ctrl_t;

  typedef struct packed {
    temp_t right;
    temp_t centre;
    temp_t left;
    temp_t up;
  } taps_t;

endpackage

/* rtl/hds_lbuf.sv */
module hds_lbuf (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_i,
  input  hds_pkg::temp_t                     cell_i,
  input  logic [hds_pkg::GridWidthW-1:0]     width_i,
  output hds_pkg::taps_t                     taps_o
);

  // Two copies of the same history so that four taps can be read per beat.
  hds_pkg::temp_t mem_a [hds_pkg::LineDepth];
  hds_pkg::temp_t mem_b [hds_pkg::LineDepth];

  logic [hds_pkg::PtrW-1:0] wr_ptr_q;
  logic [hds_pkg::PtrW-1:0] w_ext;
  logic [hds_pkg::PtrW-1:0] addr_right, addr_centre, addr_left, addr_up;
  hds_pkg::taps_t           taps_q;

  assign w_ext       = hds_pkg::PtrW'(width_i);
  assign addr_right  = wr_ptr_q - w_ext + hds_pkg::PtrW'(1);
  assign addr_centre = wr_ptr_q - w_ext;
  assign addr_left   = wr_ptr_q - w_ext - hds_pkg::PtrW'(1);
  assign addr_up     = wr_ptr_q - (w_ext << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
    end else if (wr_i) begin
      wr_ptr_q <= wr_ptr_q + hds_pkg::PtrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_a[wr_ptr_q] <= cell_i;
      mem_b[wr_ptr_q] <= cell_i;
      taps_q.right    <= mem_a[addr_right];
      taps_q.centre   <= mem_a[addr_centre];
      taps_q.left     <= mem_b[addr_left];
      taps_q.up       <= mem_b[addr_up];
    end
  end

  assign taps_o = taps_q;

endmodule

/* rtl/hds_calc.sv */
module hds_calc (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  hds_pkg::temp_t                        cur_i,
  input  hds_pkg::taps_t                        taps_i,
  input  hds_pkg::cell_ctrl_t                   ctrl_i,
  input  logic [hds_pkg::FactorW-1:0]           factor_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [hds_pkg::ProdW-1:0]      prod_o,
  output hds_pkg::temp_t                        centre_o,
  output hds_pkg::cell_ctrl_t                   ctrl_o
);

  logic                              v2_q, v3_q;
  logic                              ready2, ready3;
  logic signed [hds_pkg::LapW-1:0]   lap_d, lap_q;
  logic signed [hds_pkg::ProdW-1:0]  prod_d, prod_q;
  hds_pkg::temp_t                    centre2_q, centre3_q;
  hds_pkg::cell_ctrl_t               ctrl2_q, ctrl3_q;

  assign ready3     = !v3_q || out_ready_i;
  assign ready2     = !v2_q || ready3;
  assign in_ready_o = ready2;

  // Sum of both second differences; exact in LapW bits.
  assign lap_d = hds_pkg::LapW'(taps_i.left) + hds_pkg::LapW'(taps_i.right)
               + hds_pkg::LapW'(taps_i.up) + hds_pkg::LapW'(cur_i)
               - (hds_pkg::LapW'(taps_i.centre) <<< 2);

  assign prod_d = $signed({1'b0, factor_i}) * lap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready2) begin
        v2_q <= in_valid_i;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && in_valid_i) begin
      lap_q     <= lap_d;
      centre2_q <= taps_i.centre;
      ctrl2_q   <= ctrl_i;
    end
    if (ready3 && v2_q) begin
      prod_q    <= prod_d;
      centre3_q <= centre2_q;
      ctrl3_q   <= ctrl2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign prod_o      = prod_q;
  assign centre_o    = centre3_q;
  assign ctrl_o      = ctrl3_q;

endmodule

/* rtl/hds_out.sv */
`include "heat_diffusion_stencil_2d_assert.svh"

module hds_out (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [hds_pkg::ProdW-1:0]      prod_i,
  input  hds_pkg::temp_t                        centre_i,
  input  hds_pkg::cell_ctrl_t                   ctrl_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output hds_pkg::temp_t                        new_temperature_o,
  output logic                                  run_last_o,
  output logic                                  grid_last_o
);

  localparam int unsigned ShW  = hds_pkg::ProdW - hds_pkg::FactorW;
  localparam int unsigned SumW = ShW + 1;
  localparam logic signed [SumW-1:0] SatHi = SumW'(2 ** (hds_pkg::TempW - 1) - 1);
  localparam logic signed [SumW-1:0] SatLo = SumW'(-(2 ** (hds_pkg::TempW - 1)));

  logic signed [ShW-1:0]             shifted;
  logic signed [SumW-1:0]            sum;
  hds_pkg::temp_t                    sat, stencil;
  logic [hds_pkg::GridWidthW-1:0]    zero_cnt_q;
  logic                              out_valid_q, run_last_q, grid_last_q;
  hds_pkg::temp_t                    temp_q;
  logic                              out_free, take, flushing, load_zero, load_cell;

  // Dropping the low bits of a two's complement value rounds towards minus infinity.
  assign shifted = prod_i[hds_pkg::ProdW-1:hds_pkg::FactorW];
  assign sum     = SumW'(shifted) + SumW'(centre_i);

  always_comb begin
    if (sum > SatHi) begin
      sat = hds_pkg::temp_t'(SatHi);
    end else if (sum < SatLo) begin
      sat = hds_pkg::temp_t'(SatLo);
    end else begin
      sat = sum[hds_pkg::TempW-1:0];
    end
  end

  assign stencil = ctrl_i.interior ? sat : '0;

  assign out_free   = !out_valid_q || out_ready_i;
  assign flushing   = zero_cnt_q != '0;
  assign in_ready_o = !flushing && (!ctrl_i.emit || out_free);
  assign take       = in_valid_i && in_ready_o;
  assign load_zero  = flushing && out_free;
  assign load_cell  = take && ctrl_i.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      zero_cnt_q  <= '0;
      run_last_q  <= 1'b0;
      grid_last_q <= 1'b0;
    end else begin
      if (load_zero) begin
        out_valid_q <= 1'b1;
        run_last_q  <= zero_cnt_q == hds_pkg::GridWidthW'(1);
        grid_last_q <= zero_cnt_q == hds_pkg::GridWidthW'(1);
        zero_cnt_q  <= zero_cnt_q - hds_pkg::GridWidthW'(1);
      end else if (load_cell) begin
        out_valid_q <= 1'b1;
        run_last_q  <= !ctrl_i.flush;
        grid_last_q <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        zero_cnt_q <= ctrl_i.flush ? ctrl_i.width : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_zero) begin
      temp_q <= '0;
    end else if (load_cell) begin
      temp_q <= stencil;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign new_temperature_o = temp_q;
  assign run_last_o        = run_last_q;
  assign grid_last_o       = grid_last_q;

  `HDS_ASSERT_IMPL(a_grid_last_ends_run, clk_i, rst_ni, out_valid_q && grid_last_q, run_last_q && (zero_cnt_q == '0))
  `HDS_ASSERT_NEXT(a_flush_gives_zero, clk_i, rst_ni, flushing && out_free, out_valid_q && (temp_q == '0))
  `HDS_ASSERT_NEXT(a_flush_count_loaded, clk_i, rst_ni, take && ctrl_i.flush, zero_cnt_q == $past(ctrl_i.width))

endmodule

/* rtl/heat_diffusion_stencil_2d.sv */
// One explicit time step of 2-D heat diffusion on a streamed grid of Q8.8 cells.
// Input channel: one cell_temperature beat per cell, raster order, x fastest.
// Output channel: new_temperature beats in raster order; border cells read zero.
// run_last marks the final beat caused by an input, grid_last the grid's final cell.
// Configuration channel: cfg_index selects diffusion factor, grid width or grid
// length; writes are taken every cycle and must only occur while the block is idle.
// Throughput: one input beat per cycle while the output is not stalled, limited by the single line-buffer write.
// The final input of a grid causes width+1 output beats, so the input is held off
// while the zero bottom row is flushed.
// Registered steps from the input beat that completes a result to the output register:
// line-buffer read, stencil sum, multiply, round and saturate.
// The first row of a grid produces no output; each later row emits the row above.
// Reset clears the raster position, the pipeline and the registers to their
// defaults (factor 13107, 32 x 32 cells); line-buffer contents are undefined.
// A stalled receiver holds the output register; bubbles in the pipeline still
// fill, after which ready drops back through every stage to the input.
module heat_diffusion_stencil_2d (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hds_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [hds_pkg::FactorW-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [hds_pkg::TempW-1:0]  cell_temperature_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [hds_pkg::TempW-1:0]  new_temperature_o,
  output logic                              run_last_o,
  output logic                              grid_last_o
);

  // Configuration registers.
  logic [hds_pkg::FactorW-1:0]     factor_q;
  logic [hds_pkg::GridWidthW-1:0]  gwidth_q;
  logic [hds_pkg::GridLengthW-1:0] glength_q;

  // Raster position of the next input cell.
  logic [hds_pkg::GridWidthW-1:0]  col_q;
  logic [hds_pkg::RowW-1:0]        row_q;

  logic [hds_pkg::GridWidthW-1:0]  w_eff, wm1, col_eff;
  logic [hds_pkg::GridLengthW-1:0] l_eff;
  logic [hds_pkg::RowW-1:0]        lm1, row_eff;
  logic                            last_col, last_row, accept;
  hds_pkg::cell_ctrl_t             ctrl_d;

  // First pipeline stage: the cell beside its line-buffer taps.
  logic                            s1_valid_q;
  hds_pkg::temp_t                  s1_cur_q;
  hds_pkg::cell_ctrl_t             s1_ctrl_q;
  hds_pkg::taps_t                  taps;
  logic                            calc_ready;

  logic                            s3_valid, s3_ready;
  logic signed [hds_pkg::ProdW-1:0] s3_prod;
  hds_pkg::temp_t                  s3_centre, new_temp;
  hds_pkg::cell_ctrl_t             s3_ctrl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q  <= hds_pkg::FactorReset;
      gwidth_q  <= hds_pkg::WidthReset;
      glength_q <= hds_pkg::LengthReset;
    end else if (cfg_valid_i) begin
      unique case (hds_pkg::cfg_idx_e'(cfg_index_i))
        hds_pkg::CfgFactor: factor_q  <= cfg_data_i;
        hds_pkg::CfgWidth:  gwidth_q  <= cfg_data_i[hds_pkg::GridWidthW-1:0];
        hds_pkg::CfgLength: glength_q <= cfg_data_i[hds_pkg::GridLengthW-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range geometry is pulled back into the supported range.
  always_comb begin
    if (gwidth_q < hds_pkg::GridWidthW'(3)) begin
      w_eff = hds_pkg::GridWidthW'(3);
    end else if (gwidth_q > hds_pkg::GridWidthW'(hds_pkg::MaxWidth)) begin
      w_eff = hds_pkg::GridWidthW'(hds_pkg::MaxWidth);
    end else begin
      w_eff = gwidth_q;
    end
    if (glength_q < hds_pkg::GridLengthW'(3)) begin
      l_eff = hds_pkg::GridLengthW'(3);
    end else if (glength_q > hds_pkg::GridLengthW'(hds_pkg::MaxLength)) begin
      l_eff = hds_pkg::GridLengthW'(hds_pkg::MaxLength);
    end else begin
      l_eff = glength_q;
    end
  end

  assign wm1 = w_eff - hds_pkg::GridWidthW'(1);
  assign lm1 = hds_pkg::RowW'(l_eff - hds_pkg::GridLengthW'(1));

  // A position beyond a shrunken geometry sticks at the last column or row.
  assign col_eff  = (col_q >= w_eff) ? wm1 : col_q;
  assign row_eff  = (hds_pkg::GridLengthW'(row_q) >= l_eff) ? lm1 : row_q;
  assign last_col = col_eff == wm1;
  assign last_row = row_eff == lm1;

  // The cell arriving now completes the stencil of the cell one row above it.
  assign ctrl_d.emit     = row_eff != '0;
  assign ctrl_d.interior = (row_eff != '0) && (row_eff != hds_pkg::RowW'(1))
                         && (col_eff != '0) && !last_col;
  assign ctrl_d.flush    = last_col && last_row;
  assign ctrl_d.width    = w_eff;

  assign in_ready_o = !s1_valid_q || calc_ready;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (accept) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_eff + hds_pkg::RowW'(1);
        end else begin
          col_q <= col_eff + hds_pkg::GridWidthW'(1);
          row_q <= row_eff;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cur_q  <= cell_temperature_i;
      s1_ctrl_q <= ctrl_d;
    end
  end

  // The line buffer reads its taps on the same edge that registers the cell.
  hds_lbuf u_lbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .cell_i  (cell_temperature_i),
    .width_i (w_eff),
    .taps_o  (taps)
  );

  hds_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (calc_ready),
    .cur_i       (s1_cur_q),
    .taps_i      (taps),
    .ctrl_i      (s1_ctrl_q),
    .factor_i    (factor_q),
    .out_valid_o (s3_valid),
    .out_ready_i (s3_ready),
    .prod_o      (s3_prod),
    .centre_o    (s3_centre),
    .ctrl_o      (s3_ctrl)
  );

  hds_out u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s3_valid),
    .in_ready_o        (s3_ready),
    .prod_i            (s3_prod),
    .centre_i          (s3_centre),
    .ctrl_i            (s3_ctrl),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .new_temperature_o (new_temp),
    .run_last_o        (run_last_o),
    .grid_last_o       (grid_last_o)
  );

  assign new_temperature_o = new_temp;

endmodule

/* dv/heat_diffusion_stencil_2d_checker.sv */
`timescale 1ns / 1ps

// Watches the three channels of the stencil block. It keeps its own copy of the
// registers, the raster position and the recent cells, and queues the updated
// cells that every accepted input beat should release.
module heat_diffusion_stencil_2d_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [hds_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [hds_pkg::FactorW-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  hds_pkg::temp_t                      cell_temperature_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  hds_pkg::temp_t                      new_temperature_i,
  input  logic                                run_last_i,
  input  logic                                grid_last_i,
  output int unsigned                         pending_o,
  output int unsigned                         mismatches_o
);

  localparam int unsigned HistoryDepth = 2 * hds_pkg::MaxWidth + 2;

  typedef struct packed {
    hds_pkg::temp_t temperature;
    logic           run_last;
    logic           grid_last;
  } cell_beat_t;

  cell_beat_t                       updated_cells[$];
  hds_pkg::temp_t                   recent_cells[HistoryDepth];
  logic [hds_pkg::FactorW-1:0]      factor;
  logic [hds_pkg::GridWidthW-1:0]   width_reg;
  logic [hds_pkg::GridLengthW-1:0]  length_reg;
  int unsigned                      col;
  int unsigned                      row;
  int unsigned                      mismatches;
  int unsigned                      beats_seen;

  assign mismatches_o = mismatches;

  function automatic hds_pkg::temp_t saturate(input longint value);
    if (value > 32767) return hds_pkg::temp_t'(16'h7FFF);
    if (value < -32768) return hds_pkg::temp_t'(16'h8000);
    return hds_pkg::temp_t'(value);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t: output beat %0d, %s: got %0d, expected %0d",
             $time, beats_seen, what, got, want);
  endtask

  // Appends one expected beat at the tail of the queue.
  task automatic queue_beat(input cell_beat_t beat);
    updated_cells = {updated_cells, beat};
  endtask

  // Works out what one input cell releases and advances the raster position.
  task automatic diffuse_cell(input hds_pkg::temp_t cur);
    int unsigned    w;
    int unsigned    l;
    int unsigned    c;
    int unsigned    r;
    int unsigned    k;
    logic           closes_grid;
    hds_pkg::temp_t centre;
    longint         laplacian;
    cell_beat_t     beat;
    w = width_reg;
    l = length_reg;
    if (w < 3) w = 3;
    if (w > hds_pkg::MaxWidth) w = hds_pkg::MaxWidth;
    if (l < 3) l = 3;
    if (l > hds_pkg::MaxLength) l = hds_pkg::MaxLength;
    c = (col >= w) ? w - 1 : col;
    r = (row >= l) ? l - 1 : row;
    closes_grid = (r == l - 1) && (c == w - 1);

    // The cell one row up is released; the first row has nothing above it.
    if (r >= 1) begin
      beat = '0;
      if (c != 0 && c != w - 1 && r != 1) begin
        centre    = recent_cells[w - 1];
        laplacian = longint'(recent_cells[w - 2]) + longint'(recent_cells[w])
                  + longint'(recent_cells[2 * w - 1]) + longint'(cur)
                  - 4 * longint'(centre);
        // An arithmetic shift of the signed product rounds toward minus infinity.
        beat.temperature = saturate(((longint'(factor) * laplacian) >>> 16)
                                    + longint'(centre));
      end
      beat.run_last = !closes_grid;
      queue_beat(beat);
    end

    // The last cell of the grid also releases the all-zero bottom row.
    if (closes_grid) begin
      for (k = 0; k < w; k++) begin
        beat           = '0;
        beat.grid_last = (k == w - 1);
        beat.run_last  = (k == w - 1);
        queue_beat(beat);
      end
    end

    for (k = HistoryDepth - 1; k > 0; k--) recent_cells[k] = recent_cells[k - 1];
    recent_cells[0] = cur;

    if (c == w - 1) begin
      col = 0;
      row = (r == l - 1) ? 0 : r + 1;
    end else begin
      col = c + 1;
      row = r;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cell_beat_t want;
    if (!rst_ni) begin
      updated_cells.delete();
      foreach (recent_cells[k]) recent_cells[k] = '0;
      factor     = hds_pkg::FactorReset;
      width_reg  = hds_pkg::WidthReset;
      length_reg = hds_pkg::LengthReset;
      col        = 0;
      row        = 0;
      mismatches = 0;
      beats_seen = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (updated_cells.size() == 0) begin
          report_mismatch("beat with nothing expected, new_temperature",
                          new_temperature_i, 0);
        end else begin
          want = updated_cells.pop_front();
          if (new_temperature_i !== want.temperature)
            report_mismatch("new_temperature", new_temperature_i, want.temperature);
          if (run_last_i !== want.run_last)
            report_mismatch("run_last", run_last_i, want.run_last);
          if (grid_last_i !== want.grid_last)
            report_mismatch("grid_last", grid_last_i, want.grid_last);
        end
        beats_seen++;
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          hds_pkg::CfgFactor: factor     = cfg_data_i;
          hds_pkg::CfgWidth:  width_reg  = cfg_data_i[hds_pkg::GridWidthW-1:0];
          hds_pkg::CfgLength: length_reg = cfg_data_i[hds_pkg::GridLengthW-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) diffuse_cell(cell_temperature_i);

      pending_o <= updated_cells.size();
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

// Top of the stencil testbench. It makes the stimulus, drives the receiver's
// ready, keeps a watchdog and gives the verdict; the checker beside the block
// does all the prediction and comparison and hands back its mismatch count.
module testbench;

  // Longest quiet spell that a healthy run can show is the deliberate receiver
  // hold-off below plus a sender gap and the pipeline drain, well under this.
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned HoldOffCycles = 400;
  // Settling waits a good margin beyond the time a cell takes through the block.
  localparam int unsigned SettleCycles  = 12;
  // Rough number of input beats for the whole run.
  localparam int unsigned TotalCells    = 250;

  logic                          clk;
  logic                          rst_n       = 1'b0;
  logic                          cfg_valid   = 1'b0;
  logic                          cfg_ready;
  logic [hds_pkg::CfgIdxW-1:0]   cfg_index   = '0;
  logic [hds_pkg::FactorW-1:0]   cfg_data    = '0;
  logic                          in_valid    = 1'b0;
  logic                          in_ready;
  hds_pkg::temp_t                cell_data   = '0;
  logic                          out_valid;
  logic                          out_ready   = 1'b0;
  hds_pkg::temp_t                new_temperature;
  logic                          run_last;
  logic                          grid_last;

  int unsigned                   pending;
  int unsigned                   mismatches;

  // Shared between the sender and the receiver process: random idling on or off,
  // and a request for one long receiver hold-off.
  bit                            idle_on     = 1'b1;
  bit                            hold_req    = 1'b0;

  // The sender's own idea of the geometry in force and of the raster position,
  // used only to know where a grid closes.
  int unsigned                   grid_w      = 32;
  int unsigned                   grid_l      = 32;
  int unsigned                   raster_col  = 0;
  int unsigned                   raster_row  = 0;
  int unsigned                   cells_sent  = 0;
  int unsigned                   quiet       = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  heat_diffusion_stencil_2d DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .cell_temperature_i (cell_data),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .new_temperature_o  (new_temperature),
    .run_last_o         (run_last),
    .grid_last_o        (grid_last)
  );

  heat_diffusion_stencil_2d_checker diffusion_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .cell_temperature_i (cell_data),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .new_temperature_i  (new_temperature),
    .run_last_i         (run_last),
    .grid_last_i        (grid_last),
    .pending_o          (pending),
    .mismatches_o       (mismatches)
  );

  // The watchdog counts cycles in which no beat moves on any channel. A hung
  // block or a lost beat ends the run here.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver. Ready comes in random runs, with random stall bursts while idling
  // is on. When the sender asks for it, ready is held low for one long stretch
  // so that the pipeline fills and the input backs up.
  initial begin
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Temperatures lean on the rails and on small values around zero, where the
  // saturation and the rounding toward minus infinity are easiest to see.
  function automatic hds_pkg::temp_t pick_temp();
    case ($urandom_range(0, 7))
      0: return hds_pkg::temp_t'(16'h7FFF);
      1: return hds_pkg::temp_t'(16'h8000);
      2: return hds_pkg::temp_t'(int'($urandom_range(0, 511)) - 256);
      default: return hds_pkg::temp_t'($urandom());
    endcase
  endfunction

  function automatic int unsigned pick_factor();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Writes one register and notes the geometry it implies. Only called once the
  // block has gone idle.
  task automatic write_reg(input hds_pkg::cfg_idx_e idx, input int unsigned value);
    int unsigned v;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= hds_pkg::FactorW'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      hds_pkg::CfgWidth: begin
        v      = value & 32'h3F;
        grid_w = (v < 3) ? 3 : v;
      end
      hds_pkg::CfgLength: begin
        v      = value & 32'h7FF;
        grid_l = (v < 3) ? 3 : (v > hds_pkg::MaxLength) ? hds_pkg::MaxLength : v;
      end
      default: ;
    endcase
  endtask

  // Offers one cell beat, sometimes after a gap, and waits for it to be taken.
  // Valid stays high across back-to-back beats.
  task automatic send_cell(input hds_pkg::temp_t value);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cell_data <= value;
    do @(posedge clk); while (!in_ready);
    cells_sent++;
    // A position past a shrunken geometry sticks to the last column or row.
    if (raster_col >= grid_w) raster_col = grid_w - 1;
    if (raster_row >= grid_l) raster_row = grid_l - 1;
    if (raster_col == grid_w - 1) begin
      raster_col = 0;
      raster_row = (raster_row == grid_l - 1) ? 0 : raster_row + 1;
    end else begin
      raster_col++;
    end
  endtask

  // Random cells until the raster position comes home, closing the grid.
  task automatic finish_grid();
    do begin
      send_cell(pick_temp());
    end while (raster_col != 0 || raster_row != 0);
  endtask

  // The sender pauses until every expected beat has arrived, then lets the
  // pipeline run dry, since first-row cells release nothing to wait for.
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_grid(input int unsigned factor, input int unsigned w,
                          input int unsigned l);
    settle();
    write_reg(hds_pkg::CfgFactor, factor);
    write_reg(hds_pkg::CfgWidth, w);
    write_reg(hds_pkg::CfgLength, l);
  endtask

  // A 3 x 3 grid whose only interior cell sits amid a ring of one value.
  task automatic send_ring(input hds_pkg::temp_t ring, input hds_pkg::temp_t centre);
    int unsigned k;
    for (k = 0; k < 9; k++) send_cell((k == 4) ? centre : ring);
  endtask

  // Mostly small grids; now and then the widest row or a register below its
  // floor, with the factor often at zero or full scale.
  task automatic random_grid();
    case ($urandom_range(0, 9))
      0: set_grid(pick_factor(), hds_pkg::MaxWidth, 3);
      1: set_grid(pick_factor(), $urandom_range(0, 2), $urandom_range(3, 5));
      2: set_grid(pick_factor(), $urandom_range(3, 6), $urandom_range(0, 2));
      default: set_grid(pick_factor(), $urandom_range(3, 8), $urandom_range(3, 6));
    endcase
    finish_grid();
  endtask

  initial begin
    int unsigned k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A hot centre in a ring at the cold rail with full-scale
    // factor must saturate low, and the mirror case must saturate high.
    set_grid(65535, 3, 3);
    send_ring(hds_pkg::temp_t'(16'h8000), hds_pkg::temp_t'(16'h7FFF));
    send_ring(hds_pkg::temp_t'(16'h7FFF), hds_pkg::temp_t'(16'h8000));
    // Width and length below their floor act as three; a zero factor leaves
    // the interior unchanged.
    set_grid(0, 0, 1);
    for (k = 0; k < 9; k++) send_cell(pick_temp());

    // Random grids with idling on both sides.
    while (cells_sent < TotalCells / 3) random_grid();

    // Long receiver hold-off while the sender keeps offering a whole grid.
    set_grid(pick_factor(), 8, 6);
    hold_req = 1'b1;
    finish_grid();

    // Every line-buffer entry must have been written before the geometry is
    // changed part-way through a grid.
    while (cells_sent < 2 * hds_pkg::MaxWidth + 2) random_grid();

    // Width shrinks mid-grid: the column count is past the new width, so the
    // current row ends at the next cell.
    set_grid(pick_factor(), 8, 6);
    for (k = 0; k < 3 * 8 + 6; k++) send_cell(pick_temp());
    settle();
    write_reg(hds_pkg::CfgWidth, 4);
    finish_grid();

    // Length shrinks mid-grid: the row count is past the new length, so this
    // row becomes the last one and closes the grid.
    set_grid(pick_factor(), 5, 8);
    for (k = 0; k < 6 * 5 + 2; k++) send_cell(pick_temp());
    settle();
    write_reg(hds_pkg::CfgLength, 4);
    finish_grid();

    while (cells_sent < TotalCells - 40) random_grid();

    // The last stretch runs with no idling at all.
    settle();
    idle_on = 1'b0;
    random_grid();
    random_grid();

    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4 * SettleCycles) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* heat_diffusion_stencil_2d.f */
+incdir+rtl
rtl/hds_pkg.sv
rtl/hds_lbuf.sv
rtl/hds_calc.sv
rtl/hds_out.sv
rtl/heat_diffusion_stencil_2d.sv
dv/heat_diffusion_stencil_2d_checker.sv
dv/testbench.sv
